/* hdl/qrbe_pkg.sv */
// ----------------------------------------------------------------------------
// qrbe_pkg
// Shared types, codes and GF(2^8) helpers for the QR byte-mode RS encoder.
// ----------------------------------------------------------------------------
package qrbe_pkg;

    // Counter width covers the largest data codeword count (44)
    localparam int CNT_W     = 6;
    // Generator storage covers the largest check codeword count (30) plus one
    localparam int GEN_MAX   = 31;
    // Command queue depth between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] MODE_NIB  = 4'b0100;
    localparam logic [3:0] TERM_NIB  = 4'b0000;
    localparam logic [7:0] PAD_A     = 8'hEC;
    localparam logic [7:0] PAD_B     = 8'h11;
    localparam logic [7:0] FIELD_LOW = 8'h1D;
    localparam logic [7:0] GF_ALPHA  = 8'h02;

    // Input item kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_CHECK  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Back-end operations
    typedef enum logic [1:0] {
        OP_DATA,
        OP_CHECK,
        OP_ERR
    } t_op;

    // One classified command: lead bytes, then pad bytes (data),
    // or a remainder dump (check), or a single error beat
    typedef struct packed {
        t_op              op;
        logic             lead2;
        logic             clr;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [CNT_W-1:0] pads;
    } t_cmd;

    // GF(2^8) multiply, field polynomial 0x11D
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] xs;
        acc = '0;
        xs  = x;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) acc = acc ^ xs;
            xs = xs[7] ? ({xs[6:0], 1'b0} ^ FIELD_LOW) : {xs[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Coefficient idx of the generator with roots alpha^0 .. alpha^(c_cnt-1);
    // evaluated at elaboration only
    function automatic logic [7:0] gen_coef(input int c_cnt, input int idx);
        logic [7:0] g  [GEN_MAX];
        logic [7:0] nx [GEN_MAX];
        logic [7:0] root;
        for (int i = 0; i < GEN_MAX; i++) g[i] = '0;
        g[0] = 8'h01;
        root = 8'h01;
        for (int r = 0; r < c_cnt; r++) begin
            for (int i = 0; i < GEN_MAX; i++) nx[i] = '0;
            for (int i = 0; i <= r; i++) begin
                nx[i]     = nx[i] ^ g[i];
                nx[i + 1] = nx[i + 1] ^ gf_mul(g[i], root);
            end
            for (int i = 0; i < GEN_MAX; i++) g[i] = nx[i];
            root = gf_mul(root, GF_ALPHA);
        end
        return g[idx];
    endfunction

endpackage

/* hdl/qrbe_front.sv */
// ----------------------------------------------------------------------------
// qrbe_front
// Accepts input beats, tracks message framing and turns each item into one
// back-end command (or drops it).
// ----------------------------------------------------------------------------
module qrbe_front import qrbe_pkg::*; #(
    parameter int DATA_CW_TOTAL = 44,
    parameter int MAX_CHARS     = 42
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_message_length,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    localparam int CW1 = CNT_W + 1;
    localparam logic [CW1-1:0]   LIM    = CW1'(DATA_CW_TOTAL - 1);
    localparam logic [CNT_W-1:0] DC_CNT = CNT_W'(DATA_CW_TOTAL);

    logic             r_hdr,  n_hdr;
    logic [3:0]       r_held, n_held;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_lerr, n_lerr;

    logic             w_acc;
    logic             w_err;
    logic [CW1-1:0]   w_cnt_x;
    logic [CNT_W-1:0] w_lead_n;

    assign w_acc    = i_push && !i_full;
    assign w_err    = r_lerr || (i_message_length > 8'(MAX_CHARS));
    assign w_cnt_x  = {1'b0, r_cnt};
    assign w_lead_n = r_hdr ? CNT_W'(1) : CNT_W'(2);

    // classify the beat and work out the next framing state
    always_comb begin
        n_hdr      = r_hdr;
        n_held     = r_held;
        n_cnt      = r_cnt;
        n_lerr     = r_lerr;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (w_acc && i_kind != KIND_NONE) begin
            if (w_err) begin
                o_cmd_push = 1'b1;
                o_cmd.op   = OP_ERR;
                o_cmd.clr  = (i_kind == KIND_CHECK);
                if (i_kind == KIND_CHECK) begin
                    n_hdr  = 1'b0;
                    n_held = '0;
                    n_cnt  = '0;
                    n_lerr = 1'b0;
                end else begin
                    n_lerr = 1'b1;
                end
            end else begin
                unique case (i_kind)
                    KIND_DATA: begin
                        if (!r_hdr) begin
                            // first character: mode nibble, length, char high nibble
                            if (i_message_length != 8'd0 && (w_cnt_x + CW1'(2)) <= LIM) begin
                                o_cmd_push  = 1'b1;
                                o_cmd.op    = OP_DATA;
                                o_cmd.lead2 = 1'b1;
                                o_cmd.b0    = {MODE_NIB, i_message_length[7:4]};
                                o_cmd.b1    = {i_message_length[3:0], i_data_byte[7:4]};
                                n_cnt       = r_cnt + CNT_W'(2);
                                n_hdr       = 1'b1;
                                n_held      = i_data_byte[3:0];
                            end
                        end else begin
                            // later character: held nibble then char high nibble
                            if (r_cnt != '0 &&
                                (8'(r_cnt) - 8'd1) < i_message_length &&
                                (w_cnt_x + CW1'(1)) <= LIM) begin
                                o_cmd_push = 1'b1;
                                o_cmd.op   = OP_DATA;
                                o_cmd.b0   = {r_held, i_data_byte[7:4]};
                                n_cnt      = r_cnt + CNT_W'(1);
                                n_held     = i_data_byte[3:0];
                            end
                        end
                    end
                    KIND_FINISH: begin
                        // tail byte(s), then padding up to the data capacity
                        if (r_cnt < DC_CNT) begin
                            o_cmd_push  = 1'b1;
                            o_cmd.op    = OP_DATA;
                            o_cmd.lead2 = !r_hdr;
                            o_cmd.b0    = r_hdr ? {r_held, TERM_NIB}
                                                : {MODE_NIB, i_message_length[7:4]};
                            o_cmd.b1    = {i_message_length[3:0], TERM_NIB};
                            o_cmd.pads  = DC_CNT - r_cnt - w_lead_n;
                            n_cnt       = DC_CNT;
                            n_hdr       = 1'b1;
                            n_held      = '0;
                        end
                    end
                    default: begin
                        // check: dump remainder, start a new message
                        o_cmd_push = 1'b1;
                        o_cmd.op   = OP_CHECK;
                        n_hdr      = 1'b0;
                        n_held     = '0;
                        n_cnt      = '0;
                        n_lerr     = 1'b0;
                    end
                endcase
            end
        end
    end

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= 1'b0;
            r_held <= '0;
            r_cnt  <= '0;
            r_lerr <= 1'b0;
        end else begin
            r_hdr  <= n_hdr;
            r_held <= n_held;
            r_cnt  <= n_cnt;
            r_lerr <= n_lerr;
        end
    end

endmodule

/* hdl/qrbe_cmd_q.sv */
// ----------------------------------------------------------------------------
// qrbe_cmd_q
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module qrbe_cmd_q import qrbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd               r_ent [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_ent[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + Q_PTR_W'(1);
            if (w_rd) r_rp <= r_rp + Q_PTR_W'(1);
            if (w_wr && !w_rd)      r_cnt <= r_cnt + Q_CNT_W'(1);
            else if (w_rd && !w_wr) r_cnt <= r_cnt - Q_CNT_W'(1);
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (w_wr) r_ent[r_wp] <= i_cmd;
    end

endmodule

/* hdl/qrbe_back.sv */
// ----------------------------------------------------------------------------
// qrbe_back
// Executes queued commands one codeword per cycle while the output beat is empty or popped:
// data bytes through the byte-wide RS division, remainder dump, or error beat.
// ----------------------------------------------------------------------------
module qrbe_back import qrbe_pkg::*; #(
    parameter int CHECK_CODEWORDS = 26
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_qpop,
    output logic       o_ov,
    input  logic       i_pop,
    output logic [7:0] o_codeword,
    output logic       o_last,
    output logic       o_error
);

    localparam logic [CNT_W-1:0] CHK_LAST = CNT_W'(CHECK_CODEWORDS - 1);

    logic [7:0]       r_rem [CHECK_CODEWORDS];
    logic [CNT_W-1:0] r_step;
    logic             r_ov;
    logic [7:0]       r_cw;
    logic             r_last;
    logic             r_err;

    logic [7:0]       w_lfsr  [CHECK_CODEWORDS];
    logic [7:0]       w_shift [CHECK_CODEWORDS];
    logic             w_adv;
    logic [CNT_W-1:0] w_lead_n;
    logic [CNT_W-1:0] w_pidx;
    logic [7:0]       w_cw;
    logic             w_last;
    logic             w_err;
    logic [7:0]       w_factor;

    assign w_adv    = i_valid && (!r_ov || i_pop);
    assign o_qpop   = w_adv && w_last;
    assign w_lead_n = i_cmd.lead2 ? CNT_W'(2) : CNT_W'(1);
    assign w_pidx   = r_step - w_lead_n;
    assign w_factor = w_cw ^ r_rem[0];

    // current beat of the head command
    always_comb begin
        w_cw   = '0;
        w_last = 1'b1;
        w_err  = 1'b0;
        unique case (i_cmd.op)
            OP_DATA: begin
                if (r_step == '0)           w_cw = i_cmd.b0;
                else if (r_step < w_lead_n) w_cw = i_cmd.b1;
                else                        w_cw = w_pidx[0] ? PAD_B : PAD_A;
                w_last = (r_step == (w_lead_n + i_cmd.pads - CNT_W'(1)));
            end
            OP_CHECK: begin
                w_cw   = r_rem[0];
                w_last = (r_step == CHK_LAST);
            end
            OP_ERR: begin
                w_err = 1'b1;
            end
            default: begin
                w_err = 1'b1;
            end
        endcase
    end

    // remainder lanes: LFSR update and plain shift-out
    for (genvar i = 0; i < CHECK_CODEWORDS; i++) begin : g_lane
        localparam logic [7:0] GC = gen_coef(CHECK_CODEWORDS, i + 1);
        logic [7:0] w_up;
        if (i < CHECK_CODEWORDS - 1) begin : g_mid
            assign w_up = r_rem[i + 1];
        end else begin : g_end
            assign w_up = '0;
        end
        assign w_lfsr[i]  = w_up ^ gf_mul(GC, w_factor);
        assign w_shift[i] = w_up;
    end

    // control, remainder and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_step <= '0;
            r_rem  <= '{default: '0};
        end else begin
            if (w_adv) begin
                r_ov   <= 1'b1;
                r_step <= w_last ? '0 : r_step + CNT_W'(1);
                case (i_cmd.op)
                    OP_DATA:  r_rem <= w_lfsr;
                    OP_CHECK: r_rem <= w_shift;
                    default: begin
                        if (i_cmd.clr) r_rem <= '{default: '0};
                    end
                endcase
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cw   <= w_cw;
            r_last <= w_last;
            r_err  <= w_err;
        end
    end

    assign o_ov       = r_ov;
    assign o_codeword = r_cw;
    assign o_last     = r_last;
    assign o_error    = r_err;

endmodule

/* hdl/qr_byte_mode_rs_encoder.sv */
// An item's first result beat passes the command queue, then the back end's output register.
// The back end's single output register gives one result beat per cycle while results are popped;
//   an item gives CHECK_CODEWORDS results (check) or up to DATA_CW_TOTAL results (finish).
// Input stalls only when the 2-entry command queue is full.
// Reset (synchronous, active low) clears framing state, queue, output and RS remainder at once.
// ----------------------------------------------------------------------------
// qr_byte_mode_rs_encoder
// QR byte-mode data codeword packer with Reed-Solomon check codeword generation.
// ----------------------------------------------------------------------------
module qr_byte_mode_rs_encoder import qrbe_pkg::*; #(
    parameter int DATA_CW_TOTAL   = 44,
    parameter int CHECK_CODEWORDS = 26,
    parameter int MAX_CHARS       = 42
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_message_length,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_codeword,
    output logic       o_last,
    output logic       o_error
);

    logic w_cmd_push;
    t_cmd w_cmd_in;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;
    logic w_ov;

    // framing and classification
    qrbe_front #(
        .DATA_CW_TOTAL (DATA_CW_TOTAL),
        .MAX_CHARS     (MAX_CHARS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .o_cmd_push       (w_cmd_push),
        .o_cmd            (w_cmd_in)
    );

    // command queue
    qrbe_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // codeword emission and RS division
    qrbe_back #(
        .CHECK_CODEWORDS (CHECK_CODEWORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_cmd      (w_q_cmd),
        .o_qpop     (w_q_pop),
        .o_ov       (w_ov),
        .i_pop      (pop),
        .o_codeword (o_codeword),
        .o_last     (o_last),
        .o_error    (o_error)
    );

    assign empty = !w_ov;

endmodule
